### sv/gnta_pkg.sv
// Package for the gated nearest-track association block.
// Holds field widths, stream layouts and the opcode and result kind codes.
// No dependencies; used by gnta_dist and gated_nearest_track_association.
package gnta_pkg;

    // Field widths.
    localparam int OPC_W       = 2;
    localparam int KIND_W      = 2;
    localparam int COORD_W     = 24;
    localparam int GATE_W      = 16;
    localparam int GATE_SQ_W   = 2 * GATE_W;
    localparam int DET_W       = 16;
    localparam int TRK_OUT_W   = 5;

    // Distance arithmetic: a coordinate difference needs one more bit, its
    // square stays below 2**48, and three squares stay below 2**50.
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int DIST_W      = SQ_W + 2;

    // Stream layouts.
    localparam int S_DATA_W    = 3 * COORD_W;
    localparam int M_DATA_BITS = TRK_OUT_W + DET_W;
    localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int POS_W       = 3 * COORD_W;

    localparam logic [DET_W-1:0] DET_MAX = '1;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR     = 2'd0,
        OP_ADD_TRACK = 2'd1,
        OP_DETECT    = 2'd2,
        OP_END_FRAME = 2'd3
    } opcode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAIR          = 2'd0,
        KIND_UNASSOC_DET   = 2'd1,
        KIND_UNASSOC_TRACK = 2'd2,
        KIND_DONE          = 2'd3
    } kind_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [DIST_W-1:0]         dist_t;

endpackage

### sv/gnta_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters; no dependencies.
module gnta_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

### sv/gnta_dist.sv
// Pipelined squared-distance unit shared by every track comparison.
// Three stages: coordinate differences, squares, sum. Uses gnta_pkg.
module gnta_dist #(
    parameter int TAG_W = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [TAG_W-1:0]      in_tag,
    input  gnta_pkg::coord_t      det_x,
    input  gnta_pkg::coord_t      det_y,
    input  gnta_pkg::coord_t      det_z,
    input  gnta_pkg::coord_t      trk_x,
    input  gnta_pkg::coord_t      trk_y,
    input  gnta_pkg::coord_t      trk_z,
    output logic                  out_valid,
    output logic [TAG_W-1:0]      out_tag,
    output gnta_pkg::dist_t       out_dist
);

    import gnta_pkg::*;

    logic                     diff_v_reg;
    logic                     sq_v_reg;
    logic                     sum_v_reg;
    logic [TAG_W-1:0]         diff_tag_reg;
    logic [TAG_W-1:0]         sq_tag_reg;
    logic [TAG_W-1:0]         sum_tag_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [DIFF_W-1:0] dz_reg;
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
    logic signed [PROD_W-1:0] pz;
    logic [SQ_W-1:0]          sqx_reg;
    logic [SQ_W-1:0]          sqy_reg;
    logic [SQ_W-1:0]          sqz_reg;
    dist_t                    sum_reg;

    // Squares of the registered differences; each fits in SQ_W bits.
    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    // Valid bits of the three stages.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            diff_v_reg <= 1'b0;
            sq_v_reg   <= 1'b0;
            sum_v_reg  <= 1'b0;
        end else begin
            diff_v_reg <= in_valid;
            sq_v_reg   <= diff_v_reg;
            sum_v_reg  <= sq_v_reg;
        end
    end

    // Data path of the three stages.
    always_ff @(posedge clk) begin
        diff_tag_reg <= in_tag;
        dx_reg       <= DIFF_W'(det_x) - DIFF_W'(trk_x);
        dy_reg       <= DIFF_W'(det_y) - DIFF_W'(trk_y);
        dz_reg       <= DIFF_W'(det_z) - DIFF_W'(trk_z);

        sq_tag_reg   <= diff_tag_reg;
        sqx_reg      <= px[SQ_W-1:0];
        sqy_reg      <= py[SQ_W-1:0];
        sqz_reg      <= pz[SQ_W-1:0];

        sum_tag_reg  <= sq_tag_reg;
        sum_reg      <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);
    end

    assign out_valid = sum_v_reg;
    assign out_tag   = sum_tag_reg;
    assign out_dist  = sum_reg;

endmodule

### sv/gated_nearest_track_association.sv
// Gated nearest-track association: each frame starts with a clear item, then
// add-track items load predicted positions into a table of MAX_TRACKS slots,
// then each detection item is matched greedily to the nearest untaken track
// whose squared distance is strictly below gate_distance squared (lowest slot
// wins a tie), and an end-frame item lists the untaken tracks (only if the
// frame held a detection) followed by a done item. For a detection, the
// sequencer reads one table slot per cycle into a pipelined squared-distance
// unit, closes the scan, waits for the unit to drain, and registers the
// result. An end frame lists the untaken slots in slot order, waiting while
// the output register is full, then closes the list and sends the done item.
// The block takes no item while a detection or end frame is in work; results
// wait in an output register.
module gated_nearest_track_association #(
    parameter int MAX_TRACKS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: gate_distance.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gnta_pkg::GATE_W-1:0]    cfg_data,
    // Input items.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gnta_pkg::S_DATA_W-1:0]  s_tdata,  // pos_x, pos_y, pos_z
    input  logic [gnta_pkg::OPC_W-1:0]     s_tuser,  // opcode
    // Result items.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gnta_pkg::M_DATA_W-1:0]  m_tdata,  // track slot, detection number, pad
    output logic [gnta_pkg::KIND_W-1:0]    m_tuser,  // kind
    output logic                           m_tlast
);

    import gnta_pkg::*;

    localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W = $clog2(MAX_TRACKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TRACKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESULT,
        S_LIST,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [GATE_W-1:0]      gate_reg;
    logic [GATE_SQ_W-1:0]   gate_sq_reg;
    logic [CNT_W-1:0]       track_count_reg;
    logic [DET_W-1:0]       det_count_reg;
    logic [DET_W-1:0]       det_idx_reg;
    logic [MAX_TRACKS-1:0]  taken_reg;
    logic [CNT_W-1:0]       scan_idx_reg;
    coord_t                 det_x_reg;
    coord_t                 det_y_reg;
    coord_t                 det_z_reg;
    logic                   issue_v_reg;
    logic [IDX_W-1:0]       issue_idx_reg;
    dist_t                  best_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic                   found_reg;
    logic                   m_tvalid_reg;
    kind_t                  kind_reg;
    logic [TRK_OUT_W-1:0]   trk_out_reg;
    logic [DET_W-1:0]       det_out_reg;
    logic                   last_reg;
    logic [2:0]             inflight_reg;

    logic                   in_fire;
    opcode_t                opcode;
    logic                   out_free;
    logic                   m_load;
    logic                   scan_more;
    logic [IDX_W-1:0]       scan_idx;
    logic                   wr_en;
    logic [POS_W-1:0]       rd_pos;
    logic                   dist_v;
    logic [IDX_W-1:0]       dist_idx;
    dist_t                  dist_sq;

    assign in_fire   = s_tvalid && s_tready;
    assign opcode    = opcode_t'(s_tuser);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign scan_more = scan_idx_reg < track_count_reg;
    assign scan_idx  = scan_idx_reg[IDX_W-1:0];
    assign wr_en     = in_fire && (opcode == OP_ADD_TRACK) && (track_count_reg < CNT_MAX);

    // A new result item enters the output register in this cycle.
    assign m_load    = out_free && ((state_reg == S_RESULT) || (state_reg == S_DONE) ||
                       ((state_reg == S_LIST) && scan_more && !taken_reg[scan_idx]));

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = kind_reg;
    assign m_tlast   = last_reg;
    assign m_tdata   = M_DATA_W'({det_out_reg, trk_out_reg});

    // Track position table, one slot of x, y and z per entry.
    gnta_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_TRACKS)
    ) u_track_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (track_count_reg[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_addr (scan_idx),
        .rd_data (rd_pos)
    );

    // Shared squared-distance unit, fed one slot per cycle.
    gnta_dist #(
        .TAG_W (IDX_W)
    ) u_dist (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (issue_v_reg),
        .in_tag    (issue_idx_reg),
        .det_x     (det_x_reg),
        .det_y     (det_y_reg),
        .det_z     (det_z_reg),
        .trk_x     (coord_t'(rd_pos[COORD_W-1:0])),
        .trk_y     (coord_t'(rd_pos[2*COORD_W-1:COORD_W])),
        .trk_z     (coord_t'(rd_pos[3*COORD_W-1:2*COORD_W])),
        .out_valid (dist_v),
        .out_tag   (dist_idx),
        .out_dist  (dist_sq)
    );

    // Gate register and its square, registered from the gate register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg <= GATE_W'(768);
        end else if (cfg_valid && cfg_ready) begin
            gate_reg <= cfg_data;
        end
        gate_sq_reg <= gate_reg * gate_reg;
    end

    // Sequencer with table state and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            track_count_reg <= '0;
            det_count_reg   <= '0;
            taken_reg       <= '0;
            scan_idx_reg    <= '0;
            issue_v_reg     <= 1'b0;
            found_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            // Only untaken slots of the table enter the distance unit.
            issue_v_reg <= (state_reg == S_SCAN) && scan_more && !taken_reg[scan_idx];

            // The output register holds an item until the receiver takes it.
            if (m_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // Best candidate tracking at the end of the distance pipeline.
            if (dist_v && (dist_sq < best_reg)) begin
                best_reg     <= dist_sq;
                best_idx_reg <= dist_idx;
                found_reg    <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (opcode)
                            OP_CLEAR: begin
                                track_count_reg <= '0;
                                det_count_reg   <= '0;
                                taken_reg       <= '0;
                            end
                            OP_ADD_TRACK: begin
                                if (track_count_reg < CNT_MAX) begin
                                    taken_reg[track_count_reg[IDX_W-1:0]] <= 1'b0;
                                    track_count_reg <= track_count_reg + 1'b1;
                                end
                            end
                            OP_DETECT: begin
                                det_x_reg    <= coord_t'(s_tdata[COORD_W-1:0]);
                                det_y_reg    <= coord_t'(s_tdata[2*COORD_W-1:COORD_W]);
                                det_z_reg    <= coord_t'(s_tdata[3*COORD_W-1:2*COORD_W]);
                                det_idx_reg  <= det_count_reg;
                                if (det_count_reg != DET_MAX) begin
                                    det_count_reg <= det_count_reg + 1'b1;
                                end
                                scan_idx_reg <= '0;
                                state_reg    <= S_SCAN;
                            end
                            OP_END_FRAME: begin
                                scan_idx_reg <= '0;
                                state_reg    <= (det_count_reg != '0) ? S_LIST : S_DONE;
                            end
                        endcase
                    end
                end

                // One table slot per cycle into the distance unit.
                S_SCAN: begin
                    if (scan_idx_reg == '0) begin
                        best_reg  <= DIST_W'(gate_sq_reg);
                        found_reg <= 1'b0;
                    end
                    if (scan_more) begin
                        issue_idx_reg <= scan_idx;
                        scan_idx_reg  <= scan_idx_reg + 1'b1;
                    end else begin
                        state_reg <= S_DRAIN;
                    end
                end

                // Wait until the last slot has left the distance unit.
                S_DRAIN: begin
                    if (!issue_v_reg && !dist_v && (inflight_reg == '0)) begin
                        state_reg <= S_RESULT;
                    end
                end

                // Report the pair or the unassociated detection.
                S_RESULT: begin
                    if (out_free) begin
                        kind_reg     <= found_reg ? KIND_PAIR : KIND_UNASSOC_DET;
                        trk_out_reg  <= found_reg ? TRK_OUT_W'(best_idx_reg) : '0;
                        det_out_reg  <= det_idx_reg;
                        last_reg     <= 1'b1;
                        if (found_reg) begin
                            taken_reg[best_idx_reg] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                // List untaken tracks in slot order.
                S_LIST: begin
                    if (!scan_more) begin
                        state_reg <= S_DONE;
                    end else if (taken_reg[scan_idx]) begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end else if (out_free) begin
                        kind_reg     <= KIND_UNASSOC_TRACK;
                        trk_out_reg  <= TRK_OUT_W'(scan_idx);
                        det_out_reg  <= '0;
                        last_reg     <= 1'b0;
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end

                // Closing done item.
                S_DONE: begin
                    if (out_free) begin
                        kind_reg     <= KIND_DONE;
                        trk_out_reg  <= '0;
                        det_out_reg  <= '0;
                        last_reg     <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Tracks whether any slot is still inside the distance unit's stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= {inflight_reg[1:0], issue_v_reg};
        end
    end

`ifndef NO_ASSERTIONS
    // The distance pipeline is empty whenever the block takes a new item.
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (!issue_v_reg && !dist_v && (inflight_reg == '0)))
        else $error("distance pipeline busy while idle");

    // A chosen track always lies inside the filled part of the table.
    a_best_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && found_reg) |-> (CNT_W'(best_idx_reg) < track_count_reg))
        else $error("associated track outside table");

    // A reported pair marks its track as taken.
    a_pair_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && out_free && found_reg) |=>
            taken_reg[$past(best_idx_reg)])
        else $error("paired track not marked taken");
`endif

endmodule
